### rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared widths, types and constants
// Widths of the matrix-to-quaternion datapath, all derived from FRACTION_BITS.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int ONE           = 1 << FRACTION_BITS;
   localparam int SAT           = (ONE > 32767) ? 32767 : ONE;

   // Signed width of a branch component (radicand or off-diagonal term).
   localparam int CW    = ((FRACTION_BITS > 17) ? FRACTION_BITS : 17) + 2;
   // Sum of four squares, and the remainder of the square root.
   localparam int SUM_W = 2 * CW;
   localparam int RW    = CW + 3;
   // Quotient bits and the divider's working width.
   localparam int Q_W   = FRACTION_BITS + 1;
   localparam int DW    = CW + FRACTION_BITS + 1;
   // Latency of one division lane.
   localparam int LANE_LAT = Q_W + 1;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic [CW-1:0]        len_type;

   typedef struct packed {
      logic valid;
      logic deg;
   } ctl_type;

endpackage

### rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: branch selection
// Picks the Shepperd branch and forms the radicand and the three
// off-diagonal sums or differences as one registered vector.
// ----------------------------------------------------------------------------
module rmq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [15:0]    r00, r01, r02,
   input  logic signed [15:0]    r10, r11, r12,
   input  logic signed [15:0]    r20, r21, r22,
   output rmq_pkg::ctl_type      ctl,
   output rmq_pkg::comp_type     comp [4]
);
   import rmq_pkg::*;

   comp_type m00, m01, m02, m10, m11, m12, m20, m21, m22, one_c, trace, rad;
   comp_type comp_in [4];
   logic     valid_ff;
   logic     deg_ff;
   comp_type comp_ff [4];

   assign m00 = CW'(r00);
   assign m01 = CW'(r01);
   assign m02 = CW'(r02);
   assign m10 = CW'(r10);
   assign m11 = CW'(r11);
   assign m12 = CW'(r12);
   assign m20 = CW'(r20);
   assign m21 = CW'(r21);
   assign m22 = CW'(r22);
   assign one_c = CW'(ONE);
   assign trace = m00 + m11 + m22;

   always_comb begin
      if (trace > 0) begin
         rad        = one_c + trace;
         comp_in[0] = rad;
         comp_in[1] = m21 - m12;
         comp_in[2] = m02 - m20;
         comp_in[3] = m10 - m01;
      end else if (r00 > r11 && r00 > r22) begin
         rad        = one_c + m00 - m11 - m22;
         comp_in[0] = m21 - m12;
         comp_in[1] = rad;
         comp_in[2] = m01 + m10;
         comp_in[3] = m02 + m20;
      end else if (r11 > r22) begin
         rad        = one_c + m11 - m00 - m22;
         comp_in[0] = m02 - m20;
         comp_in[1] = m01 + m10;
         comp_in[2] = rad;
         comp_in[3] = m12 + m21;
      end else begin
         rad        = one_c + m22 - m00 - m11;
         comp_in[0] = m10 - m01;
         comp_in[1] = m02 + m20;
         comp_in[2] = m12 + m21;
         comp_in[3] = rad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff  <= (rad <= 0);
         comp_ff <= comp_in;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.deg   = deg_ff;
   assign comp      = comp_ff;

endmodule

### rtl/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt: square root stage
// Squares the four components, sums them and takes the integer square root
// in a pipeline that settles one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  rmq_pkg::ctl_type      in_ctl,
   input  rmq_pkg::comp_type     in_comp [4],
   output rmq_pkg::ctl_type      out_ctl,
   output rmq_pkg::comp_type     out_comp [4],
   output rmq_pkg::len_type      out_len
);
   import rmq_pkg::*;

   // Square stage.
   logic             sq_v_ff, sq_d_ff;
   comp_type         sq_c_ff [4];
   logic [SUM_W-3:0] sq_ff [4];
   // Sum stage.
   logic             sm_v_ff, sm_d_ff;
   comp_type         sm_c_ff [4];
   logic [SUM_W-1:0] sum_ff;
   // Root stages.
   logic             v_ff   [CW];
   logic             d_ff   [CW];
   comp_type         c_ff   [CW][4];
   logic [SUM_W-1:0] val_ff [CW];
   logic [RW-1:0]    rem_ff [CW];
   logic [CW-1:0]    root_ff[CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
         sm_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff <= in_ctl.valid;
         sm_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_d_ff <= in_ctl.deg;
         sq_c_ff <= in_comp;
         for (int k = 0; k < 4; k++) begin
            sq_ff[k] <= (SUM_W-2)'(in_comp[k] * in_comp[k]);
         end
         sm_d_ff <= sq_d_ff;
         sm_c_ff <= sq_c_ff;
         sum_ff  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1])
                  + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      end
   end

   for (genvar i = 0; i < CW; i++) begin : g_root
      logic             v_src, d_src, ge;
      comp_type         c_src [4];
      logic [SUM_W-1:0] val_src;
      logic [RW-1:0]    rem_src, rem_sh, trial;
      logic [CW-1:0]    root_src;

      if (i == 0) begin : g_first
         assign v_src    = sm_v_ff;
         assign d_src    = sm_d_ff;
         assign c_src    = sm_c_ff;
         assign val_src  = sum_ff;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign d_src    = d_ff[i-1];
         assign c_src    = c_ff[i-1];
         assign val_src  = val_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      assign rem_sh = {rem_src[RW-3:0], val_src[SUM_W-1 -: 2]};
      assign trial  = RW'({root_src, 2'b01});
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[i]    <= d_src;
            c_ff[i]    <= c_src;
            val_ff[i]  <= val_src << 2;
            rem_ff[i]  <= ge ? rem_sh - trial : rem_sh;
            root_ff[i] <= {root_src[CW-2:0], ge};
         end
      end
   end

   assign out_ctl.valid = v_ff[CW-1];
   assign out_ctl.deg   = d_ff[CW-1];
   assign out_comp      = c_ff[CW-1];
   assign out_len       = root_ff[CW-1];

endmodule

### rtl/rmq_div_lane.sv
// ----------------------------------------------------------------------------
// rmq_div_lane: one normalization lane
// Divides one component by the vector length with rounding to nearest,
// one quotient bit per stage, then saturates and restores the sign.
// ----------------------------------------------------------------------------
module rmq_div_lane (
   input  logic                  clock,
   input  logic                  en,
   input  rmq_pkg::comp_type     comp,
   input  rmq_pkg::len_type      len,
   output logic signed [15:0]    quot
);
   import rmq_pkg::*;

   logic [CW-1:0]  mag;
   logic           neg_ff [LANE_LAT];
   logic [DW-1:0]  rem_ff [LANE_LAT];
   logic [CW-1:0]  len_ff [LANE_LAT];
   logic [Q_W-1:0] q_ff   [LANE_LAT];
   logic [Q_W-1:0] q_sat;
   logic [15:0]    q16;

   assign mag = (comp < 0) ? CW'(-comp) : CW'(comp);

   // Numerator with half the divisor added, so truncation rounds to nearest.
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= (comp < 0);
         rem_ff[0] <= (DW'(mag) << FRACTION_BITS) + DW'(len >> 1);
         len_ff[0] <= len;
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 1; j < LANE_LAT; j++) begin : g_bit
      localparam int SH = Q_W - j;
      logic [DW-1:0] dvs;
      logic          ge;

      assign dvs = DW'(len_ff[j-1]) << SH;
      assign ge  = (rem_ff[j-1] >= dvs);

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[j] <= neg_ff[j-1];
            len_ff[j] <= len_ff[j-1];
            rem_ff[j] <= ge ? rem_ff[j-1] - dvs : rem_ff[j-1];
            q_ff[j]   <= {q_ff[j-1][Q_W-2:0], ge};
         end
      end
   end

   assign q_sat = (q_ff[LANE_LAT-1] > Q_W'(SAT)) ? Q_W'(SAT) : q_ff[LANE_LAT-1];
   assign q16   = 16'(q_sat);
   assign quot  = neg_ff[LANE_LAT-1] ? -$signed(q16) : $signed(q16);

endmodule

### rtl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation matrix to unit quaternion
// Shepperd branch selection, length by pipelined square root, and four
// parallel division lanes that normalize the quaternion.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    r00 .. r22, signed Q2.14
//  rsp_      out        rsp_valid/stall    quat_w/x/y/z Q2.14, degenerate
//
// One beat is accepted per cycle while req_stall is low; a result passes the
// branch stage, the square and sum stages, the one-bit-per-stage square root,
// the one-bit-per-stage divider lanes and the output register.
// Reset clears every valid bit of the pipeline; payload registers keep data.
// The whole pipeline holds while a result waits under rsp_stall, and
// req_stall is raised in exactly those cycles.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_r00, req_r01, req_r02,
   input  logic signed [15:0]  req_r10, req_r11, req_r12,
   input  logic signed [15:0]  req_r20, req_r21, req_r22,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_quat_w,
   output logic signed [15:0]  rsp_quat_x,
   output logic signed [15:0]  rsp_quat_y,
   output logic signed [15:0]  rsp_quat_z,
   output logic                rsp_degenerate
);
   import rmq_pkg::*;

   logic               en;
   ctl_type            fr_ctl, rt_ctl;
   comp_type           fr_comp [4];
   comp_type           rt_comp [4];
   len_type            rt_len;
   logic signed [15:0] lane_q [4];
   ctl_type            ctl_ff [LANE_LAT];
   logic               rsp_valid_ff, rsp_deg_ff;
   logic signed [15:0] rsp_q_ff [4];

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   rmq_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .r00(req_r00), .r01(req_r01), .r02(req_r02),
      .r10(req_r10), .r11(req_r11), .r12(req_r12),
      .r20(req_r20), .r21(req_r21), .r22(req_r22),
      .ctl(fr_ctl), .comp(fr_comp)
   );

   rmq_isqrt u_isqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(fr_ctl), .in_comp(fr_comp),
      .out_ctl(rt_ctl), .out_comp(rt_comp), .out_len(rt_len)
   );

   for (genvar k = 0; k < 4; k++) begin : g_lane
      rmq_div_lane u_lane (
         .clock(clock), .en(en), .comp(rt_comp[k]), .len(rt_len),
         .quot(lane_q[k])
      );
   end

   // Control travels beside the lanes so it lines up with the quotients.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            ctl_ff[s] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         ctl_ff[0] <= rt_ctl;
         for (int s = 1; s < LANE_LAT; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         rsp_valid_ff <= ctl_ff[LANE_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_deg_ff <= ctl_ff[LANE_LAT-1].deg;
         if (ctl_ff[LANE_LAT-1].deg) begin
            rsp_q_ff[0] <= 16'(SAT);
            rsp_q_ff[1] <= '0;
            rsp_q_ff[2] <= '0;
            rsp_q_ff[3] <= '0;
         end else begin
            rsp_q_ff <= lane_q;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_quat_w     = rsp_q_ff[0];
   assign rsp_quat_x     = rsp_q_ff[1];
   assign rsp_quat_y     = rsp_q_ff[2];
   assign rsp_quat_z     = rsp_q_ff[3];

endmodule

### rtl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker: port-level checks
// Watches the top level's ports and flags results or handshakes that
// break the block's rules.
// ----------------------------------------------------------------------------
module rmq_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [15:0]  rsp_quat_w,
   input logic signed [15:0]  rsp_quat_x,
   input logic signed [15:0]  rsp_quat_y,
   input logic signed [15:0]  rsp_quat_z,
   input logic                rsp_degenerate
);
   import rmq_pkg::*;

   localparam logic signed [15:0] SAT_P = 16'(SAT);
   localparam logic signed [15:0] SAT_N = -16'(SAT);

   // A degenerate result is exactly the identity quaternion.
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_w == SAT_P && rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0)
      else $error("degenerate result is not the identity");

   // Normalized components never exceed one in magnitude.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_quat_w <= SAT_P && rsp_quat_w >= SAT_N &&
         rsp_quat_x <= SAT_P && rsp_quat_x >= SAT_N &&
         rsp_quat_y <= SAT_P && rsp_quat_y >= SAT_N &&
         rsp_quat_z <= SAT_P && rsp_quat_z >= SAT_N)
      else $error("quaternion component out of range");

   // A stalled output back-pressures the input in the same cycle.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while output beat is stalled");

   // A stalled output beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x) &&
         $stable(rsp_quat_y) && $stable(rsp_quat_z) && $stable(rsp_degenerate))
      else $error("stalled output beat changed");

   // Reset leaves the output valid low.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);
